>>> design/sba_pkg.sv
// Shared constants, codes and types of the SRAM block allocator.
`timescale 1ns / 1ps

package sba_pkg;

	localparam int MAX_ENTRIES   = 256;
	localparam int POOL_BYTES    = 8192;
	localparam int GRANULE_BYTES = 32;
	localparam int POOL_GRANULES = POOL_BYTES / GRANULE_BYTES;

	localparam int ADDR_W     = 32;
	localparam int REQ_W      = 14;
	localparam int IDX_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
	localparam int OFF_W      = $clog2(POOL_GRANULES);
	localparam int BLK_W      = $clog2(POOL_GRANULES + 1);
	localparam int TAIL_W     = BLK_W + 1;
	localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
	localparam int NEED_W     = REQ_W - GRAN_SHIFT + 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TABLE_FULL = 2'd1,
		ST_NO_MEMORY  = 2'd2,
		ST_BAD_FREE   = 2'd3
	} status_t;

	// One table entry: size and offset in granules, plus the in-use mark.
	typedef struct packed {
		logic [BLK_W-1:0] blocks;
		logic [OFF_W-1:0] offset;
		logic             busy;
	} entry_t;

	typedef struct packed {
		logic              cmd;
		logic [REQ_W-1:0]  req_size;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] block_addr;
	} res_t;

endpackage

>>> design/sba_engine.sv
// Entry table memory and the scan sequencer that serves one request at a time.
`timescale 1ns / 1ps

module sba_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sba_pkg::ADDR_W-1:0] pool_base,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  sba_pkg::req_t              req,
	output logic                       res_valid,
	input  logic                       res_ready,
	output sba_pkg::res_t              res
);

	typedef enum logic [1:0] {IDLE, SCAN, DECIDE, RESP} state_t;

	state_t                       state_q;
	logic                         cmd_q;
	logic [sba_pkg::NEED_W-1:0]   need_q;
	logic [sba_pkg::ADDR_W-1:0]   where_q;
	logic [sba_pkg::CNT_W-1:0]    count_q;
	logic [sba_pkg::CNT_W-1:0]    issue_q;
	logic [sba_pkg::CNT_W-1:0]    keep_q;
	logic [sba_pkg::TAIL_W-1:0]   tail_q;
	logic                         found_q;
	sba_pkg::res_t                res_q;

	logic                         rd_vld_s1;
	logic [sba_pkg::CNT_W-1:0]    eval_idx_s1;
	sba_pkg::entry_t              rd_data_s1;

	sba_pkg::entry_t              mem [sba_pkg::MAX_ENTRIES];

	logic                         rd_en;
	logic                         wr_en;
	logic [sba_pkg::IDX_W-1:0]    wr_addr;
	sba_pkg::entry_t              wr_data;

	logic [sba_pkg::REQ_W:0]      req_round;
	logic [sba_pkg::NEED_W-1:0]   need_in;
	logic [sba_pkg::ADDR_W-1:0]   eval_addr;
	logic [sba_pkg::ADDR_W-1:0]   tail_addr;
	logic                         alloc_hit;
	logic                         free_hit;
	logic [sba_pkg::NEED_W:0]     end_sum;
	logic                         fits;
	logic                         full;
	logic                         scan_done;

	assign req_ready = (state_q == IDLE);
	assign res_valid = (state_q == RESP);
	assign res       = res_q;

	// Round the request up to whole granules; zero asks for one granule.
	assign req_round = {1'b0, req.req_size} + (sba_pkg::REQ_W + 1)'(sba_pkg::GRANULE_BYTES - 1);
	assign need_in   = (req.req_size == '0) ? sba_pkg::NEED_W'(1)
		: req_round[sba_pkg::REQ_W:sba_pkg::GRAN_SHIFT];

	assign eval_addr = pool_base
		+ (sba_pkg::ADDR_W'(rd_data_s1.offset) << sba_pkg::GRAN_SHIFT);
	assign tail_addr = pool_base + (sba_pkg::ADDR_W'(tail_q) << sba_pkg::GRAN_SHIFT);

	assign alloc_hit = !rd_data_s1.busy
		&& (sba_pkg::NEED_W'(rd_data_s1.blocks) == need_q);
	assign free_hit  = !found_q && (eval_addr == where_q);

	assign end_sum = (sba_pkg::NEED_W + 1)'(need_q) + (sba_pkg::NEED_W + 1)'(tail_q);
	assign fits    = end_sum <= (sba_pkg::NEED_W + 1)'(sba_pkg::POOL_GRANULES);
	assign full    = (count_q == sba_pkg::CNT_W'(sba_pkg::MAX_ENTRIES));

	assign rd_en     = (state_q == SCAN) && (issue_q != count_q);
	assign scan_done = !rd_vld_s1 && (issue_q == count_q);

	// Single write port: the entry under evaluation, or the appended entry.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = eval_idx_s1[sba_pkg::IDX_W-1:0];
		wr_data = rd_data_s1;
		if (state_q == SCAN && rd_vld_s1) begin
			if (cmd_q == sba_pkg::CMD_ALLOC && alloc_hit) begin
				wr_en        = 1'b1;
				wr_data.busy = 1'b1;
			end else if (cmd_q == sba_pkg::CMD_FREE && free_hit) begin
				wr_en        = 1'b1;
				wr_data.busy = 1'b0;
			end
		end else if (state_q == DECIDE && cmd_q == sba_pkg::CMD_ALLOC && !full && fits) begin
			wr_en          = 1'b1;
			wr_addr        = count_q[sba_pkg::IDX_W-1:0];
			wr_data.blocks = sba_pkg::BLK_W'(need_q);
			wr_data.offset = sba_pkg::OFF_W'(tail_q);
			wr_data.busy   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[issue_q[sba_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			keep_q      <= '0;
			tail_q      <= '0;
			found_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			eval_idx_s1 <= '0;
			cmd_q       <= sba_pkg::CMD_ALLOC;
			need_q      <= '0;
			where_q     <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						cmd_q     <= req.cmd;
						need_q    <= need_in;
						where_q   <= req.free_addr;
						issue_q   <= '0;
						keep_q    <= '0;
						tail_q    <= '0;
						found_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q   <= SCAN;
					end
				end
				SCAN: begin
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						eval_idx_s1 <= issue_q;
						issue_q     <= issue_q + sba_pkg::CNT_W'(1);
					end
					if (rd_vld_s1) begin
						tail_q <= sba_pkg::TAIL_W'(rd_data_s1.offset)
							+ sba_pkg::TAIL_W'(rd_data_s1.blocks);
						if (cmd_q == sba_pkg::CMD_ALLOC) begin
							if (alloc_hit) begin
								res_q   <= '{status: sba_pkg::ST_OK, block_addr: eval_addr};
								state_q <= RESP;
							end
						end else begin
							if (free_hit) begin
								found_q <= 1'b1;
							end else if (rd_data_s1.busy) begin
								keep_q <= eval_idx_s1 + sba_pkg::CNT_W'(1);
							end
						end
					end else if (scan_done) begin
						state_q <= DECIDE;
					end
				end
				DECIDE: begin
					state_q <= RESP;
					if (cmd_q == sba_pkg::CMD_ALLOC) begin
						if (full) begin
							res_q <= '{status: sba_pkg::ST_TABLE_FULL, block_addr: '0};
						end else if (!fits) begin
							res_q <= '{status: sba_pkg::ST_NO_MEMORY, block_addr: '0};
						end else begin
							res_q   <= '{status: sba_pkg::ST_OK, block_addr: tail_addr};
							count_q <= count_q + sba_pkg::CNT_W'(1);
						end
					end else begin
						if (found_q) begin
							res_q   <= '{status: sba_pkg::ST_OK, block_addr: '0};
							count_q <= keep_q;
						end else begin
							res_q <= '{status: sba_pkg::ST_BAD_FREE, block_addr: '0};
						end
					end
				end
				RESP: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/sram_block_allocator_core.sv
// Top level of the SRAM block allocator: stream ports, base register and result register.
`timescale 1ns / 1ps

// The allocator manages an 8 KiB pool as an ordered table of up to 256 entries, each
// holding a size and an offset in 32-byte granules and an in-use mark; entries tile the
// pool from offset zero upward. An allocate request (tuser 0) rounds req_size up to whole
// granules, with zero counting as one granule, reuses the first free entry of exactly
// that size, or else appends a new entry after the last one if it fits. A free request
// (tuser 1) clears the in-use mark of the live entry whose address equals free_addr and
// then drops every unused entry behind the last one in use; an address that matches no
// live entry returns status 3 and leaves the table untouched. Block addresses are
// pool_base plus the entry offset in bytes, so writing pool_base moves every live block.
// The table sits in a single-port-read, single-port-write synchronous RAM with registered
// read data, and every request walks the live entries (up to 256) one per cycle through
// that read port, but an allocate that reuses entry i stops its walk at that entry. One
// request is in work at a time; a new request is taken as soon as the previous result
// sits in the output register, even if it was not yet taken. The table needs no
// clearing after reset, since only live entries are read.
// pool_base must be written only while no request is in work.

module sram_block_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel: pool_base.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // [13:0] req_size, [45:14] free_addr, [47:46] zero
	input  logic        s_tuser,    // [0] cmd
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] block_addr
	output logic [1:0]  m_tuser     // [1:0] status
);

	logic [sba_pkg::ADDR_W-1:0] pool_base_q;
	logic                       m_tvalid_q;
	sba_pkg::res_t              out_q;

	sba_pkg::req_t              req;
	sba_pkg::res_t              res;
	logic                       res_valid;
	logic                       res_ready;

	// The base register can always take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
		end else if (cfg_valid) begin
			pool_base_q <= cfg_data;
		end
	end

	assign req.cmd       = s_tuser;
	assign req.req_size  = s_tdata[13:0];
	assign req.free_addr = s_tdata[45:14];

	sba_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.pool_base (pool_base_q),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: the engine hands over its result whenever this slot is free
	// or is being emptied in the same cycle.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q.block_addr;
	assign m_tuser  = out_q.status;

	// A request is served alone: right after acceptance no further request is taken.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another one is in work");

	// Any failing status carries a zero block address.
	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != sba_pkg::ST_OK)) |-> (m_tdata == '0))
		else $error("failing result with nonzero block address");

	// A result that was just loaded comes from a request that left the engine busy.
	a_result_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && s_tready) |=> !(m_tvalid && !$past(m_tvalid) && $past(s_tready)))
		else $error("result appeared without a request in work");

endmodule
